// ===== hw/rtl/acpu_pkg.sv =====
// Package for the stepped 8-bit accumulator processor: codes, states and sizes.
package acpu_pkg;

  localparam int unsigned MEM_DEPTH = 256;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [31:0] DEFAULT_LIMIT = 32'd10000;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

  // opcodes
  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_STA = 8'h10;
  localparam logic [7:0] OP_LDA = 8'h20;
  localparam logic [7:0] OP_ADD = 8'h30;
  localparam logic [7:0] OP_OR  = 8'h50;
  localparam logic [7:0] OP_AND = 8'h60;
  localparam logic [7:0] OP_NOT = 8'h70;
  localparam logic [7:0] OP_JMP = 8'h80;
  localparam logic [7:0] OP_JN  = 8'h90;
  localparam logic [7:0] OP_JZ  = 8'hA0;
  localparam logic [7:0] OP_HLT = 8'hF0;

  // item kinds (bit 1 alone selects a register reset)
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;

  typedef enum logic [2:0] {
    ST_EXECUTED = 3'd0,
    ST_HALTED   = 3'd1,
    ST_INVALID  = 3'd2,
    ST_LIMIT    = 3'd3,
    ST_WRITTEN  = 3'd4,
    ST_RESET    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPCODE,
    S_ADDR,
    S_OPND,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/accumulator_cpu_8bit_step_core.sv =====
// Top level: stepped 8-bit accumulator processor with its 256-byte memory.
//
// Input channel (in_valid/in_ready) carries one item per beat: kind 0 writes
// load_data to memory at load_address, kind 1 executes one instruction, kind
// 2 or 3 resets the processor registers (memory is kept). Every item gives
// exactly one result beat on the output channel (out_valid/out_ready) with a
// status code and a snapshot of AC, PC, IR, MAR, MDR, N, Z, HALT and the
// saturating executed-instruction count.
// Path: loads, resets and refused steps (halted, limit) go straight to the done
// state and then into the result register; an executed step first passes the
// opcode, address and operand read states as needed (a store issues with the
// address). Rate: one load, reset or refused step per cycle unless the output
// stalls; an executed step holds off the next item until it reaches done.
// The output register holds one finished result; the next item is accepted
// and executed while it waits, and that item then holds in a done state
// until the output register is free. A stalled receiver therefore holds off
// the input after at most one more item.
// The user writes step_limit (zero means 10000) through cfg_wen/cfg_wdata while
// idle, not enforced by the block. Reset (rst, synchronous) clears the registers,
// all memory valid marks (unwritten bytes read as zero), sets step_limit to 10000.
module accumulator_cpu_8bit_step_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [31:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             kind,
  input  logic [7:0]             load_address,
  input  logic [7:0]             load_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output acpu_pkg::status_t      status,
  output logic [7:0]             accumulator,
  output logic [7:0]             program_counter,
  output logic [7:0]             instruction,
  output logic [7:0]             mem_address_reg,
  output logic [7:0]             mem_data_reg,
  output logic                   negative_flag,
  output logic                   zero_flag,
  output logic                   halted_flag,
  output logic [31:0]            step_count
);
  import acpu_pkg::*;

  state_t state, state_next;

  logic [31:0] step_limit;

  // architectural registers
  logic [7:0]  acc, acc_next;
  logic [7:0]  pc, pc_next;
  logic [7:0]  ir, ir_next;
  logic [7:0]  mar, mar_next;
  logic [7:0]  mdr, mdr_next;
  logic        nflag, nflag_next;
  logic        zflag, zflag_next;
  logic        halt, halt_next;
  logic [31:0] count, count_next;
  status_t     item_status, item_status_next;

  // memory
  logic [7:0]        mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld;
  logic [7:0]        mem_q;
  logic              vld_q;
  logic [7:0]        rdata;
  logic [ADDR_W-1:0] raddr;
  logic              wen;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  logic        in_acc;
  logic        push;
  logic [31:0] limit;
  logic [31:0] count_inc;
  logic [7:0]  acc_res;

  assign push      = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) || ((state == S_DONE) && push);
  assign in_acc    = in_valid && in_ready;
  assign limit     = (step_limit == 32'd0) ? DEFAULT_LIMIT : step_limit;
  assign count_inc = (count == COUNT_MAX) ? count : count + 32'd1;
  assign rdata     = vld_q ? mem_q : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= DEFAULT_LIMIT;
    end else if (cfg_wen) begin
      step_limit <= cfg_wdata;
    end
  end

  // synchronous memory, one read and one write port; a byte never written
  // since reset reads as zero through its valid mark
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wen) begin
        mem_vld[waddr] <= 1'b1;
      end
      vld_q <= mem_vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      acc         <= '0;
      pc          <= '0;
      ir          <= '0;
      mar         <= '0;
      mdr         <= '0;
      nflag       <= 1'b0;
      zflag       <= 1'b1;
      halt        <= 1'b0;
      count       <= '0;
      item_status <= ST_EXECUTED;
    end else begin
      state       <= state_next;
      acc         <= acc_next;
      pc          <= pc_next;
      ir          <= ir_next;
      mar         <= mar_next;
      mdr         <= mdr_next;
      nflag       <= nflag_next;
      zflag       <= zflag_next;
      halt        <= halt_next;
      count       <= count_next;
      item_status <= item_status_next;
    end
  end

  // ALU for the operand stage
  always_comb begin
    case (ir)
      OP_ADD:  acc_res = acc + rdata;
      OP_OR:   acc_res = acc | rdata;
      OP_AND:  acc_res = acc & rdata;
      default: acc_res = rdata;
    endcase
  end

  always_comb begin
    state_next       = state;
    acc_next         = acc;
    pc_next          = pc;
    ir_next          = ir;
    mar_next         = mar;
    mdr_next         = mdr;
    nflag_next       = nflag;
    zflag_next       = zflag;
    halt_next        = halt;
    count_next       = count;
    item_status_next = item_status;
    raddr            = pc;
    wen              = 1'b0;
    waddr            = load_address;
    wdata            = load_data;

    case (state)
      S_OPCODE: begin
        ir_next  = rdata;
        mar_next = pc;
        mdr_next = rdata;
        pc_next  = pc + 8'd1;
        raddr    = pc + 8'd1;
        item_status_next = ST_EXECUTED;
        state_next = S_DONE;
        case (rdata)
          OP_NOP: begin
            count_next = count_inc;
          end
          OP_NOT: begin
            acc_next   = ~acc;
            nflag_next = ~acc[7];
            zflag_next = (acc == 8'hFF);
            count_next = count_inc;
          end
          OP_HLT: begin
            halt_next  = 1'b1;
            count_next = count_inc;
          end
          OP_STA, OP_LDA, OP_ADD, OP_OR, OP_AND, OP_JMP, OP_JN, OP_JZ: begin
            state_next = S_ADDR;
          end
          default: begin
            halt_next        = 1'b1;
            item_status_next = ST_INVALID;
          end
        endcase
      end

      S_ADDR: begin
        // rdata is the address byte fetched at pc
        raddr      = rdata;
        pc_next    = pc + 8'd1;
        mar_next   = pc;
        mdr_next   = rdata;
        count_next = count_inc;
        state_next = S_DONE;
        case (ir)
          OP_STA: begin
            mar_next = rdata;
            mdr_next = acc;
            wen      = 1'b1;
            waddr    = rdata;
            wdata    = acc;
          end
          OP_JMP: begin
            pc_next = rdata;
          end
          OP_JN: begin
            if (nflag) begin
              pc_next = rdata;
            end
          end
          OP_JZ: begin
            if (zflag) begin
              pc_next = rdata;
            end
          end
          default: begin
            // LDA, ADD, OR, AND: operand read is in flight
            mar_next   = rdata;
            count_next = count;
            state_next = S_OPND;
          end
        endcase
      end

      S_OPND: begin
        mdr_next   = rdata;
        acc_next   = acc_res;
        nflag_next = acc_res[7];
        zflag_next = (acc_res == 8'h00);
        count_next = count_inc;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (push) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // a new beat is taken in idle, or in done as the result leaves
    if (in_acc) begin
      state_next = S_DONE;
      if (kind[1]) begin
        acc_next         = '0;
        pc_next          = '0;
        ir_next          = '0;
        mar_next         = '0;
        mdr_next         = '0;
        nflag_next       = 1'b0;
        zflag_next       = 1'b1;
        halt_next        = 1'b0;
        count_next       = '0;
        item_status_next = ST_RESET;
      end else if (kind == KIND_LOAD) begin
        wen              = 1'b1;
        waddr            = load_address;
        wdata            = load_data;
        item_status_next = ST_WRITTEN;
      end else if (halt) begin
        item_status_next = ST_HALTED;
      end else if (count >= limit) begin
        item_status_next = ST_LIMIT;
      end else begin
        raddr      = pc;
        state_next = S_OPCODE;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && push) begin
      status          <= item_status;
      accumulator     <= acc;
      program_counter <= pc;
      instruction     <= ir;
      mem_address_reg <= mar;
      mem_data_reg    <= mdr;
      negative_flag   <= nflag;
      zero_flag       <= zflag;
      halted_flag     <= halt;
      step_count      <= count;
    end
  end

`ifndef ASSERT_OFF
  a_done_pushes: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && push |=> out_valid)
    else $error("finished result not presented");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halt && (state == S_IDLE) && !(in_acc && kind[1]) |=> halt)
    else $error("halt cleared without a reset item");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(in_acc && kind[1]) |=> (count >= $past(count)))
    else $error("step count decreased");

  a_no_accept_midstep: assert property (@(posedge clk) disable iff (rst)
    (state == S_OPCODE) || (state == S_ADDR) || (state == S_OPND) |-> !in_ready)
    else $error("input accepted during an instruction");
`endif

endmodule

// ===== tb/acpu_step_checker.sv =====
// Checker for the stepped accumulator processor: mirrors the machine and compares result beats.
module acpu_step_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [7:0]        load_address,
  input  logic [7:0]        load_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  acpu_pkg::status_t status,
  input  logic [7:0]        accumulator,
  input  logic [7:0]        program_counter,
  input  logic [7:0]        instruction,
  input  logic [7:0]        mem_address_reg,
  input  logic [7:0]        mem_data_reg,
  input  logic              negative_flag,
  input  logic              zero_flag,
  input  logic              halted_flag,
  input  logic [31:0]       step_count,
  output int                errors,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import acpu_pkg::*;

  typedef struct packed {
    status_t     st;
    logic [7:0]  acc;
    logic [7:0]  pc;
    logic [7:0]  ir;
    logic [7:0]  mar;
    logic [7:0]  mdr;
    logic        n;
    logic        z;
    logic        halt;
    logic [31:0] count;
  } machine_view_t;

  logic [7:0]  mem_image [MEM_DEPTH];
  logic [7:0]  ac, pc, ir, mar, mdr;
  logic        n_flag, z_flag, halt;
  logic [31:0] exec_count, limit_reg;

  machine_view_t pending_views [$];
  int            fail_count = 0;

  assign errors = fail_count;

  function automatic void clear_regs();
    ac = 8'h00; pc = 8'h00; ir = 8'h00; mar = 8'h00; mdr = 8'h00;
    n_flag = 1'b0; z_flag = 1'b1; halt = 1'b0;
    exec_count = 32'd0;
  endfunction

  function automatic logic [7:0] fetch_next();
    mar = pc;
    mdr = mem_image[mar];
    pc  = pc + 8'd1;
    return mdr;
  endfunction

  function automatic void read_operand(logic [7:0] a);
    mar = a;
    mdr = mem_image[a];
  endfunction

  function automatic void refresh_nz();
    z_flag = (ac == 8'h00);
    n_flag = ac[7];
  endfunction

  // one input beat in, the register snapshot it leaves behind out
  function automatic machine_view_t advance_machine(logic [1:0] k, logic [7:0] addr,
                                                    logic [7:0] data);
    machine_view_t v;
    status_t       st;
    logic [31:0]   lim;
    logic [7:0]    a;
    lim = (limit_reg == 32'd0) ? DEFAULT_LIMIT : limit_reg;
    if (k[1]) begin
      clear_regs();
      st = ST_RESET;
    end else if (k == KIND_LOAD) begin
      mem_image[addr] = data;
      st = ST_WRITTEN;
    end else if (halt) begin
      st = ST_HALTED;
    end else if (exec_count >= lim) begin
      st = ST_LIMIT;
    end else begin
      st = ST_EXECUTED;
      ir = fetch_next();
      case (ir)
        OP_NOP: ;
        OP_STA: begin
          a = fetch_next();
          mar = a;
          mdr = ac;
          mem_image[a] = ac;
        end
        OP_LDA: begin
          a = fetch_next(); read_operand(a); ac = mdr; refresh_nz();
        end
        OP_ADD: begin
          a = fetch_next(); read_operand(a); ac = ac + mdr; refresh_nz();
        end
        OP_OR: begin
          a = fetch_next(); read_operand(a); ac = ac | mdr; refresh_nz();
        end
        OP_AND: begin
          a = fetch_next(); read_operand(a); ac = ac & mdr; refresh_nz();
        end
        OP_NOT: begin
          ac = ~ac; refresh_nz();
        end
        OP_JMP: begin
          a = fetch_next(); pc = a;
        end
        OP_JN: begin
          a = fetch_next(); if (n_flag) pc = a;
        end
        OP_JZ: begin
          a = fetch_next(); if (z_flag) pc = a;
        end
        OP_HLT: halt = 1'b1;
        default: begin
          halt = 1'b1;
          st = ST_INVALID;
        end
      endcase
      // an invalid opcode is not counted
      if (st == ST_EXECUTED && exec_count != COUNT_MAX) exec_count = exec_count + 32'd1;
    end
    v.st = st;      v.acc = ac;      v.pc = pc;  v.ir = ir;    v.mar = mar;
    v.mdr = mdr;    v.n = n_flag;    v.z = z_flag; v.halt = halt; v.count = exec_count;
    return v;
  endfunction

  always @(posedge clk) begin
    machine_view_t got, want;
    if (rst) begin
      foreach (mem_image[i]) mem_image[i] = 8'h00;
      clear_regs();
      limit_reg = DEFAULT_LIMIT;
      pending_views.delete();
    end else begin
      if (cfg_wen) limit_reg = cfg_wdata;
      if (in_valid && in_ready)
        pending_views.push_back(advance_machine(kind, load_address, load_data));
      if (out_valid && out_ready) begin
        got.st = status;           got.acc = accumulator;      got.pc = program_counter;
        got.ir = instruction;      got.mar = mem_address_reg;  got.mdr = mem_data_reg;
        got.n = negative_flag;     got.z = zero_flag;          got.halt = halted_flag;
        got.count = step_count;
        if (pending_views.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with nothing expected (status %0d)", $realtime,
                     got.st);
        end else begin
          want = pending_views.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch (expected/actual)", $realtime);
              $display("  st %0d/%0d ac %h/%h pc %h/%h ir %h/%h mar %h/%h mdr %h/%h",
                       want.st, got.st, want.acc, got.acc, want.pc, got.pc,
                       want.ir, got.ir, want.mar, got.mar, want.mdr, got.mdr);
              $display("  n %b/%b z %b/%b halt %b/%b count %0d/%0d",
                       want.n, got.n, want.z, got.z, want.halt, got.halt,
                       want.count, got.count);
            end
          end
        end
      end
    end
    outstanding <= pending_views.size();
  end

endmodule

// ===== tb/accumulator_cpu_8bit_step_core_tb.sv =====
// Testbench top for the stepped accumulator processor: stimulus, stalls and verdict.
module accumulator_cpu_8bit_step_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acpu_pkg::*;

  localparam logic [1:0] KIND_RESET     = 2'd2;
  localparam logic [1:0] KIND_RESET_ALT = 2'd3;  // bit 1 alone decodes reset
  localparam int ITEMS_PER_PHASE = 560;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;
  logic        in_valid = 1'b0;
  logic [1:0]  kind = 2'd0;
  logic [7:0]  load_address = 8'h00;
  logic [7:0]  load_data = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready, out_valid;
  status_t     status;
  logic [7:0]  accumulator, program_counter, instruction, mem_address_reg, mem_data_reg;
  logic        negative_flag, zero_flag, halted_flag;
  logic [31:0] step_count;

  int errors, outstanding;
  int items_sent = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 77;
  int hold_requests = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  accumulator_cpu_8bit_step_core dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .load_address(load_address), .load_data(load_data),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .accumulator(accumulator), .program_counter(program_counter),
    .instruction(instruction), .mem_address_reg(mem_address_reg),
    .mem_data_reg(mem_data_reg), .negative_flag(negative_flag),
    .zero_flag(zero_flag), .halted_flag(halted_flag), .step_count(step_count)
  );

  acpu_step_checker chk (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .load_address(load_address), .load_data(load_data),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .accumulator(accumulator), .program_counter(program_counter),
    .instruction(instruction), .mem_address_reg(mem_address_reg),
    .mem_data_reg(mem_data_reg), .negative_flag(negative_flag),
    .zero_flag(zero_flag), .halted_flag(halted_flag), .step_count(step_count),
    .errors(errors), .outstanding(outstanding)
  );

  task automatic send_item(logic [1:0] k, logic [7:0] a, logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    kind         <= k;
    load_address <= a;
    load_data    <= d;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // an optional reset, a little data, a short program from address 0, then some steps
  task automatic run_session();
    int         len;
    logic [7:0] at, op;
    if ($urandom_range(5) != 0)
      send_item({1'b1, 1'($urandom_range(1))}, 8'($urandom), 8'($urandom));
    repeat ($urandom_range(1, 4))
      send_item(KIND_LOAD, 8'($urandom_range(192, 255)), 8'($urandom));
    len = $urandom_range(1, 8);
    at = 8'h00;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(11))
        0:  op = OP_NOP;
        1:  op = OP_STA;
        2:  op = OP_LDA;
        3:  op = OP_ADD;
        4:  op = OP_OR;
        5:  op = OP_AND;
        6:  op = OP_NOT;
        7:  op = OP_JMP;
        8:  op = OP_JN;
        9:  op = OP_JZ;
        10: op = OP_HLT;
        default: op = 8'($urandom);
      endcase
      send_item(KIND_LOAD, at, op);
      at++;
      case (op)
        OP_JMP, OP_JN, OP_JZ: begin
          send_item(KIND_LOAD, at, 8'($urandom_range(0, 2 * len)));
          at++;
        end
        OP_STA, OP_LDA, OP_ADD, OP_OR, OP_AND: begin
          send_item(KIND_LOAD, at, ($urandom_range(3) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(192, 255)));
          at++;
        end
        default: ;
      endcase
    end
    repeat ($urandom_range(1, len + 4)) begin
      if ($urandom_range(11) == 0) send_noise();
      else send_item(KIND_STEP, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_phase(int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(9) == 0) send_noise();
      else run_session();
    end
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("accumulator_cpu_8bit_step_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_limit(32'd3);

    // extremes, wrap-around add, step limit, both reset codes
    send_item(KIND_LOAD, 8'hFF, 8'hFF);
    send_item(KIND_LOAD, 8'h00, OP_LDA);
    send_item(KIND_LOAD, 8'h01, 8'hFF);
    send_item(KIND_LOAD, 8'h02, OP_ADD);
    send_item(KIND_LOAD, 8'h03, 8'hFF);
    send_item(KIND_LOAD, 8'h04, OP_NOT);
    repeat (4) send_item(KIND_STEP, 8'h00, 8'h00);
    send_item(KIND_RESET_ALT, 8'hFF, 8'hFF);
    send_item(KIND_STEP, 8'hFF, 8'hFF);
    send_item(KIND_RESET, 8'h00, 8'h00);
    // NOP, HLT, then a step on a halted machine
    send_item(KIND_LOAD, 8'h00, OP_NOP);
    send_item(KIND_LOAD, 8'h01, OP_HLT);
    repeat (3) send_item(KIND_STEP, 8'h00, 8'h00);
    // opcode byte that matches nothing
    send_item(KIND_RESET, 8'h00, 8'h00);
    send_item(KIND_LOAD, 8'h00, 8'h0F);
    repeat (2) send_item(KIND_STEP, 8'h00, 8'h00);
    wait_drained();

    write_limit(32'd7);
    hold_requests++;
    run_phase(ITEMS_PER_PHASE);
    wait_drained();

    send_idle_pct = 77;
    recv_idle_pct = 26;
    write_limit(32'hFFFF_FFFF);
    run_phase(ITEMS_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(32'd0);
    run_phase(ITEMS_PER_PHASE);
    wait_drained();
    repeat (8) @(posedge clk);

    if (errors == 0 && outstanding == 0)
      $display("accumulator_cpu_8bit_step_core test passed");
    else
      $display("accumulator_cpu_8bit_step_core test failed");
    $finish;
  end

endmodule
